>>> rtl/log_ratio_edge_detector_macros.svh
// Assertion macros for the log-ratio edge detector.
`ifndef LOG_RATIO_EDGE_DETECTOR_MACROS_SVH
`define LOG_RATIO_EDGE_DETECTOR_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define LRED_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lred assertion failed");
// Check a property on every clock edge, reset included.
`define LRED_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("lred assertion failed");
`else
`define LRED_ASSERT(label, prop)
`define LRED_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> rtl/lred_pkg.sv
// Shared constants and types for the log-ratio edge detector.
package lred_pkg;

  localparam int MAX_LINE_PIXELS = 1024;
  localparam int COL_W           = $clog2(MAX_LINE_PIXELS);
  localparam int WEFF_W          = COL_W + 1;

  localparam int PIX_W      = 8;
  localparam int LUMA_W     = 16;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 16;
  localparam int THRESH_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int LUMA_R = 77;
  localparam int LUMA_G = 154;
  localparam int LUMA_B = 25;

  localparam int MIN_DIM = 3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THRESHOLD = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEM,
    ST_CC,
    ST_C4,
    ST_UD,
    ST_LR,
    ST_P,
    ST_T,
    ST_CMP
  } state_t;

endpackage

>>> rtl/lred_pix_if.sv
// Pixel input channel: valid, ready and one RGB pixel.
interface lred_pix_if;
  logic                     valid;
  logic                     ready;
  logic [lred_pkg::PIX_W-1:0] red;
  logic [lred_pkg::PIX_W-1:0] green;
  logic [lred_pkg::PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/lred_res_if.sv
// Result channel: valid, ready, edge flag and end-of-frame mark.
interface lred_res_if;
  logic valid;
  logic ready;
  logic is_edge;
  logic frame_last;

  modport source (output valid, output is_edge, output frame_last, input ready);
  modport sink   (input valid, input is_edge, input frame_last, output ready);
endinterface

>>> rtl/lred_cfg_if.sv
// Configuration write channel: valid, ready, register index and data.
interface lred_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lred_pkg::CFG_IDX_W-1:0]  index;
  logic [lred_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/lred_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lred_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/log_ratio_edge_detector.sv
// Top level of the log-ratio edge detector: sequencer, line stores and shared multiplier.
//
// Usage:
//   in_pix  takes RGB pixels in raster order, one item per valid/ready handshake.
//   out_res gives one item per interior pixel: is_edge and frame_last; border
//           pixels give none. frame_last marks the last interior pixel of a frame.
//   cfg_wr  writes image_width (0), image_height (1) and ratio_threshold (2);
//           it is always ready. A geometry write restarts the frame position.
// Sequence:
//   An interior pixel goes from acceptance to a loaded result through an
//   accept step, a line-store read step, six passes through the single
//   32x16 multiplier and a compare step. A border pixel stops after the first pass.
//   The multiplier chain sets the rate; in_pix.ready is high only between items.
//   Results sit in an output register; the next pixel is accepted while a
//   result waits, and the compare step holds until that register is free.
// Reset:
//   rst_n clears the sequencer, position, window and output valid, and loads
//   the register defaults (640 x 480, threshold 1.0). The line stores are not
//   cleared; they fill during the first two rows of a frame.
module log_ratio_edge_detector (
  input  logic         clk,
  input  logic         rst_n,
  lred_pix_if.sink     in_pix,
  lred_res_if.source   out_res,
  lred_cfg_if.sink     cfg_wr
);

  `include "log_ratio_edge_detector_macros.svh"

  // Configuration registers
  logic [lred_pkg::WIDTH_W-1:0]  image_width_r;
  logic [lred_pkg::HEIGHT_W-1:0] image_height_r;
  logic [lred_pkg::THRESH_W-1:0] ratio_threshold_r;

  // Sequencer and position
  lred_pkg::state_t              state_r, state_nxt;
  logic [lred_pkg::COL_W-1:0]    col_r;
  logic [lred_pkg::HEIGHT_W-1:0] row_r;
  logic [3*lred_pkg::PIX_W-1:0]  window_r;
  logic [lred_pkg::PIX_W-1:0]    left_r;

  // Per-item payload
  logic [lred_pkg::PIX_W-1:0]    y_r;
  logic [lred_pkg::PIX_W-1:0]    up_r;
  logic [lred_pkg::PIX_W-1:0]    dn_r;
  logic                          emit_r;
  logic                          last_r;
  logic                          lastcol_r;
  logic [lred_pkg::MUL_A_W-1:0]  lhs_r;
  logic [lred_pkg::MUL_B_W-1:0]  t1_r;
  logic [lred_pkg::PROD_W-1:0]   prod_r;

  // Output register
  logic out_valid_r;
  logic out_edge_r;
  logic out_last_r;

  // Derived geometry
  logic [lred_pkg::WEFF_W-1:0]   w_eff;
  logic [lred_pkg::HEIGHT_W-1:0] h_eff;
  logic [lred_pkg::WEFF_W-1:0]   w_last;
  logic [lred_pkg::WEFF_W-1:0]   col_ext;
  logic [lred_pkg::WEFF_W-1:0]   col_inc;
  logic [lred_pkg::HEIGHT_W:0]   row_inc;

  // Control
  logic in_accept;
  logic cfg_accept;
  logic restart;
  logic out_free;
  logic mul_en;
  logic lhs_ld;
  logic t1_ld;
  logic out_ld;
  logic edge_flag;

  logic [lred_pkg::MUL_A_W-1:0]  mul_a;
  logic [lred_pkg::MUL_B_W-1:0]  mul_b;
  logic [lred_pkg::PROD_W-1:0]   prod_nxt;
  logic [lred_pkg::LUMA_W-1:0]   lum_sum;

  // Line store ports
  logic                         la_we, l2a_we;
  logic [lred_pkg::COL_W-1:0]   st_waddr;
  logic [lred_pkg::PIX_W-1:0]   la_wdata, l2a_wdata;
  logic [lred_pkg::COL_W-1:0]   la_raddr, l2a_raddr;
  logic [lred_pkg::PIX_W-1:0]   la_rdata, l2a_rdata;

  // Window taps: left sample, center, right sample of the row above
  logic [lred_pkg::PIX_W-1:0] win_lf, win_c, win_rt;

  assign win_lf = window_r[3*lred_pkg::PIX_W-1:2*lred_pkg::PIX_W];
  assign win_c  = window_r[2*lred_pkg::PIX_W-1:lred_pkg::PIX_W];
  assign win_rt = window_r[lred_pkg::PIX_W-1:0];

  always_comb begin
    if (image_width_r < lred_pkg::WIDTH_W'(lred_pkg::MIN_DIM)) begin
      w_eff = lred_pkg::WEFF_W'(lred_pkg::MIN_DIM);
    end else if (lred_pkg::WEFF_W'(image_width_r) > lred_pkg::WEFF_W'(lred_pkg::MAX_LINE_PIXELS)
                 || (image_width_r >> lred_pkg::WEFF_W) != '0) begin
      w_eff = lred_pkg::WEFF_W'(lred_pkg::MAX_LINE_PIXELS);
    end else begin
      w_eff = lred_pkg::WEFF_W'(image_width_r);
    end
  end

  assign h_eff   = (image_height_r < lred_pkg::HEIGHT_W'(lred_pkg::MIN_DIM))
                   ? lred_pkg::HEIGHT_W'(lred_pkg::MIN_DIM) : image_height_r;
  assign w_last  = w_eff - lred_pkg::WEFF_W'(1);
  assign col_ext = {1'b0, col_r};
  assign col_inc = col_ext + lred_pkg::WEFF_W'(1);
  assign row_inc = {1'b0, row_r} + (lred_pkg::HEIGHT_W+1)'(1);

  assign lum_sum = lred_pkg::LUMA_W'(lred_pkg::LUMA_R) * lred_pkg::LUMA_W'(in_pix.red)
                 + lred_pkg::LUMA_W'(lred_pkg::LUMA_G) * lred_pkg::LUMA_W'(in_pix.green)
                 + lred_pkg::LUMA_W'(lred_pkg::LUMA_B) * lred_pkg::LUMA_W'(in_pix.blue);

  assign in_pix.ready = (state_r == lred_pkg::ST_IDLE);
  assign in_accept    = in_pix.valid && in_pix.ready;
  assign cfg_wr.ready = 1'b1;
  assign cfg_accept   = cfg_wr.valid && cfg_wr.ready;
  assign restart      = cfg_accept && (cfg_wr.index == lred_pkg::CFG_IMAGE_WIDTH
                                       || cfg_wr.index == lred_pkg::CFG_IMAGE_HEIGHT);
  assign out_free     = !out_valid_r || out_res.ready;

  assign prod_nxt  = mul_a * mul_b;
  assign edge_flag = {{(lred_pkg::PROD_W-lred_pkg::MUL_A_W-lred_pkg::PIX_W){1'b0}},
                      lhs_r, {lred_pkg::PIX_W{1'b0}}} > prod_r;

  // Line stores read the column under the pixel and the one before it
  assign la_raddr  = col_r;
  assign l2a_raddr = col_r - lred_pkg::COL_W'(1);

  lred_ram #(.WIDTH(lred_pkg::PIX_W), .DEPTH(lred_pkg::MAX_LINE_PIXELS)) u_line_above (
    .clk   (clk),
    .we    (la_we),
    .waddr (st_waddr),
    .wdata (la_wdata),
    .raddr (la_raddr),
    .rdata (la_rdata)
  );

  lred_ram #(.WIDTH(lred_pkg::PIX_W), .DEPTH(lred_pkg::MAX_LINE_PIXELS)) u_line_two_above (
    .clk   (clk),
    .we    (l2a_we),
    .waddr (st_waddr),
    .wdata (l2a_wdata),
    .raddr (l2a_raddr),
    .rdata (l2a_rdata)
  );

  // Sequencer: next state, multiplier operands and store writes
  always_comb begin
    state_nxt = state_r;
    mul_en    = 1'b0;
    lhs_ld    = 1'b0;
    t1_ld     = 1'b0;
    out_ld    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    la_we     = 1'b0;
    l2a_we    = 1'b0;
    st_waddr  = col_r - lred_pkg::COL_W'(1);
    la_wdata  = left_r;
    l2a_wdata = win_rt;
    unique case (state_r)
      lred_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = lred_pkg::ST_MEM;
        end
      end
      lred_pkg::ST_MEM: begin
        // shift the previous column down one row
        la_we     = (col_r != '0);
        l2a_we    = (col_r != '0);
        state_nxt = lred_pkg::ST_CC;
      end
      lred_pkg::ST_CC: begin
        // last column: store it now, it is not revisited this row
        la_we     = lastcol_r;
        l2a_we    = lastcol_r;
        st_waddr  = w_last[lred_pkg::COL_W-1:0];
        la_wdata  = y_r;
        mul_en    = 1'b1;
        mul_a     = lred_pkg::MUL_A_W'(win_c);
        mul_b     = lred_pkg::MUL_B_W'(win_c);
        state_nxt = emit_r ? lred_pkg::ST_C4 : lred_pkg::ST_IDLE;
      end
      lred_pkg::ST_C4: begin
        mul_en    = 1'b1;
        mul_a     = lred_pkg::MUL_A_W'(prod_r[lred_pkg::MUL_B_W-1:0]);
        mul_b     = prod_r[lred_pkg::MUL_B_W-1:0];
        state_nxt = lred_pkg::ST_UD;
      end
      lred_pkg::ST_UD: begin
        lhs_ld    = 1'b1;
        mul_en    = 1'b1;
        mul_a     = lred_pkg::MUL_A_W'(up_r);
        mul_b     = lred_pkg::MUL_B_W'(dn_r);
        state_nxt = lred_pkg::ST_LR;
      end
      lred_pkg::ST_LR: begin
        t1_ld     = 1'b1;
        mul_en    = 1'b1;
        mul_a     = lred_pkg::MUL_A_W'(win_lf);
        mul_b     = lred_pkg::MUL_B_W'(win_rt);
        state_nxt = lred_pkg::ST_P;
      end
      lred_pkg::ST_P: begin
        mul_en    = 1'b1;
        mul_a     = lred_pkg::MUL_A_W'(t1_r);
        mul_b     = prod_r[lred_pkg::MUL_B_W-1:0];
        state_nxt = lred_pkg::ST_T;
      end
      lred_pkg::ST_T: begin
        mul_en    = 1'b1;
        mul_a     = prod_r[lred_pkg::MUL_A_W-1:0];
        mul_b     = ratio_threshold_r;
        state_nxt = lred_pkg::ST_CMP;
      end
      lred_pkg::ST_CMP: begin
        // hold until the output register is free
        if (out_free) begin
          out_ld    = 1'b1;
          state_nxt = lred_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lred_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lred_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration, position, window and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r     <= lred_pkg::WIDTH_RESET;
      image_height_r    <= lred_pkg::HEIGHT_RESET;
      ratio_threshold_r <= lred_pkg::THRESH_RESET;
      col_r             <= '0;
      row_r             <= '0;
      window_r          <= '0;
      left_r            <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_accept) begin
        unique case (cfg_wr.index)
          lred_pkg::CFG_IMAGE_WIDTH:     image_width_r     <= cfg_wr.data[lred_pkg::WIDTH_W-1:0];
          lred_pkg::CFG_IMAGE_HEIGHT:    image_height_r    <= cfg_wr.data;
          lred_pkg::CFG_RATIO_THRESHOLD: ratio_threshold_r <= cfg_wr.data;
          default: begin
          end
        endcase
      end
      if (restart) begin
        col_r    <= '0;
        row_r    <= '0;
        window_r <= '0;
        left_r   <= '0;
      end else if (state_r == lred_pkg::ST_MEM) begin
        window_r <= {window_r[2*lred_pkg::PIX_W-1:0], la_rdata};
        left_r   <= y_r;
        // advance the raster position
        if (col_inc >= w_eff) begin
          col_r <= '0;
          if (row_inc >= {1'b0, h_eff}) begin
            row_r <= '0;
          end else begin
            row_r <= row_inc[lred_pkg::HEIGHT_W-1:0];
          end
        end else begin
          col_r <= col_inc[lred_pkg::COL_W-1:0];
        end
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-item datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      y_r <= lum_sum[lred_pkg::LUMA_W-1:lred_pkg::LUMA_W-lred_pkg::PIX_W];
    end
    if (state_r == lred_pkg::ST_MEM) begin
      up_r      <= l2a_rdata;
      dn_r      <= left_r;
      emit_r    <= (row_r >= lred_pkg::HEIGHT_W'(2)) && (col_r >= lred_pkg::COL_W'(2));
      last_r    <= (row_r == h_eff - lred_pkg::HEIGHT_W'(1)) && (col_ext == w_last);
      lastcol_r <= (col_ext == w_last);
    end
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
    if (lhs_ld) begin
      lhs_r <= prod_r[lred_pkg::MUL_A_W-1:0];
    end
    if (t1_ld) begin
      t1_r <= prod_r[lred_pkg::MUL_B_W-1:0];
    end
    if (out_ld) begin
      out_edge_r <= edge_flag;
      out_last_r <= last_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.is_edge    = out_edge_r;
  assign out_res.frame_last = out_last_r;

  // A result is loaded only from the compare step
  `LRED_ASSERT(a_load_from_cmp, $rose(out_valid_r) |-> $past(state_r) == lred_pkg::ST_CMP)
  // A pending result is never overwritten
  `LRED_ASSERT(a_cmp_holds, state_r == lred_pkg::ST_CMP && out_valid_r && !out_res.ready
               |=> state_r == lred_pkg::ST_CMP)
  // The end-of-frame result leaves the position at the frame start
  `LRED_ASSERT(a_last_wraps, state_r == lred_pkg::ST_CMP && last_r |-> col_r == '0 && row_r == '0)
  // Between items the column stays inside the row
  `LRED_ASSERT(a_col_in_row, state_r == lred_pkg::ST_IDLE |-> col_ext < w_eff)

endmodule

>>> tb/tb_log_ratio_edge_detector.sv
// Self-checking testbench for the log-ratio edge detector: directed and random frames.
module tb_log_ratio_edge_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import lred_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 800000;
  localparam int unsigned RANDOM_PIXELS = 850;
  localparam int unsigned WIDE_PIXELS   = 100;
  localparam int unsigned SETTLE_CYCLES = 20;

  // Index with no register behind it; a write must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {
    STYLE_UNIFORM,
    STYLE_FLAT,
    STYLE_SPARSE,
    STYLE_MIXED
  } pix_style_t;

  class edge_flag_board;
    typedef struct packed {
      logic is_edge;
      logic frame_last;
    } edge_flag_t;

    edge_flag_t          flags_due[$];
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic [PIX_W-1:0]    luma_above     [MAX_LINE_PIXELS];
    logic [PIX_W-1:0]    luma_two_above [MAX_LINE_PIXELS];
    logic [3*PIX_W-1:0]  mid_window;
    logic [PIX_W-1:0]    luma_left;
    int unsigned         col_pos;
    int unsigned         row_pos;
    int unsigned         failures;
    int unsigned         flags_checked;
    int unsigned         flags_set;
    int unsigned         frames_done;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      thresh_reg = THRESH_RESET;
      restart_frame();
    endfunction

    function void restart_frame();
      mid_window = '0;
      luma_left  = '0;
      col_pos    = 0;
      row_pos    = 0;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH: begin
          width_reg = data[WIDTH_W-1:0];
          restart_frame();
        end
        CFG_IMAGE_HEIGHT: begin
          height_reg = data[HEIGHT_W-1:0];
          restart_frame();
        end
        CFG_RATIO_THRESHOLD: begin
          thresh_reg = data[THRESH_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Advance the window by one pixel and queue the flag of the interior pixel it completes.
    function void take_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
      int unsigned       w;
      int unsigned       h;
      int unsigned       c;
      int unsigned       rw;
      logic [PIX_W-1:0]  luma;
      logic [PIX_W-1:0]  up;
      longint unsigned   cv;
      longint unsigned   uv;
      longint unsigned   dv;
      longint unsigned   lv;
      longint unsigned   rv;
      longint unsigned   tv;
      longint unsigned   lhs;
      longint unsigned   rhs;
      edge_flag_t        flag;
      w = width_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_LINE_PIXELS) w = MAX_LINE_PIXELS;
      h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
      c = col_pos;
      rw = row_pos;
      luma = PIX_W'((LUMA_R * r + LUMA_G * g + LUMA_B * b) >> 8);
      up = '0;
      mid_window = {mid_window[2*PIX_W-1:0], luma_above[c]};
      if (c >= 1) begin
        up = luma_two_above[c-1];
        luma_two_above[c-1] = luma_above[c-1];
        luma_above[c-1] = luma_left;
      end
      if (rw >= 2 && c >= 2) begin
        cv = mid_window[2*PIX_W-1:PIX_W];
        lv = mid_window[3*PIX_W-1:2*PIX_W];
        rv = mid_window[PIX_W-1:0];
        uv = up;
        dv = luma_left;
        tv = thresh_reg;
        lhs = cv * cv * cv * cv * 256;
        rhs = tv * (uv * dv * lv * rv);
        flag.is_edge    = (lhs > rhs);
        flag.frame_last = (rw == h - 1) && (c == w - 1);
        flags_due.push_back(flag);
      end
      if (c == w - 1) begin
        luma_two_above[c] = luma_above[c];
        luma_above[c] = luma;
      end
      luma_left = luma;
      c++;
      if (c >= w) begin
        c = 0;
        rw++;
        if (rw >= h) rw = 0;
      end
      col_pos = c;
      row_pos = rw;
    endfunction

    function void check_result(logic is_edge, logic frame_last);
      edge_flag_t want;
      if (flags_due.size() == 0) begin
        note_failure($sformatf("result with none pending: is_edge=%0b frame_last=%0b",
                               is_edge, frame_last));
        return;
      end
      want = flags_due.pop_front();
      if (is_edge !== want.is_edge)
        note_failure($sformatf("flag %0d: is_edge expected %0b, got %0b",
                               flags_checked, want.is_edge, is_edge));
      if (frame_last !== want.frame_last)
        note_failure($sformatf("flag %0d: frame_last expected %0b, got %0b",
                               flags_checked, want.frame_last, frame_last));
      flags_checked++;
      if (want.is_edge) flags_set++;
      if (want.frame_last) frames_done++;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lred_pix_if pix_if();
  lred_res_if res_if();
  lred_cfg_if cfg_if();

  log_ratio_edge_detector u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_if),
    .out_res (res_if),
    .cfg_wr  (cfg_if)
  );

  edge_flag_board board;
  int unsigned    pix_taken     = 0;
  int unsigned    cfg_taken     = 0;
  int unsigned    cycle_count   = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    random_pixels = 0;
  int unsigned    settings_run  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: drop ready at random, per cycle.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        board.write_reg(cfg_if.index, cfg_if.data);
        cfg_taken = cfg_taken + 1;
      end
      if (pix_if.valid && pix_if.ready) begin
        board.take_pixel(pix_if.red, pix_if.green, pix_if.blue);
        pix_taken = pix_taken + 1;
      end
      if (res_if.valid && res_if.ready)
        board.check_result(res_if.is_edge, res_if.frame_last);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b);
    int unsigned seen;
    // Idle at random, per cycle, before offering the item.
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_if.valid = 1'b0;
      @(negedge clk);
    end
    pix_if.valid = 1'b1;
    pix_if.red   = r;
    pix_if.green = g;
    pix_if.blue  = b;
    seen = pix_taken;
    do @(negedge clk); while (pix_taken == seen);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    int unsigned seen;
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    seen = cfg_taken;
    do @(negedge clk); while (cfg_taken == seen);
    cfg_if.valid = 1'b0;
  endtask

  // Hold off until every flag is out and a pixel that gives none has cleared the block.
  task automatic settle_block();
    pix_if.valid = 1'b0;
    while (board.flags_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void make_pixel(input pix_style_t style, input logic [PIX_W-1:0] base,
                                     output logic [PIX_W-1:0] r, output logic [PIX_W-1:0] g,
                                     output logic [PIX_W-1:0] b);
    pix_style_t pick;
    int         v;
    pick = style;
    if (style == STYLE_MIXED) pick = pix_style_t'($urandom_range(0, 2));
    r = PIX_W'($urandom_range(0, 255));
    g = PIX_W'($urandom_range(0, 255));
    b = PIX_W'($urandom_range(0, 255));
    case (pick)
      STYLE_FLAT: begin
        // Gray near one level keeps the ratio close to one, where the threshold decides.
        v = int'(base) + int'($urandom_range(0, 8)) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        if ($urandom_range(0, 9) != 0) begin
          r = PIX_W'(v);
          g = PIX_W'(v);
          b = PIX_W'(v);
        end
      end
      STYLE_SPARSE: begin
        if ($urandom_range(0, 9) < 7) begin
          r = '0;
          g = '0;
          b = '0;
        end
      end
      default: begin
      end
    endcase
    if (style == STYLE_MIXED && $urandom_range(0, 15) == 0) begin
      r = '1;
      g = '1;
      b = '1;
    end
  endfunction

  task automatic run_phase(input bit new_geometry, input logic [CFG_DATA_W-1:0] width_data,
                           input logic [CFG_DATA_W-1:0] height_data,
                           input logic [CFG_DATA_W-1:0] thresh_data,
                           input int unsigned pixels, input pix_style_t style,
                           input bit counts_random);
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] base;
    settle_block();
    if (new_geometry) begin
      write_cfg(CFG_IMAGE_WIDTH, width_data);
      write_cfg(CFG_IMAGE_HEIGHT, height_data);
    end
    write_cfg(CFG_RATIO_THRESHOLD, thresh_data);
    settings_run++;
    base = PIX_W'($urandom_range(0, 255));
    repeat (pixels) begin
      if (counts_random) begin
        if (random_pixels < RANDOM_PIXELS / 3) begin
          send_idle_pct = 37;
          recv_idle_pct = 71;
        end else if (random_pixels < 2 * RANDOM_PIXELS / 3) begin
          send_idle_pct = 71;
          recv_idle_pct = 37;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        random_pixels++;
      end
      make_pixel(style, base, r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    int unsigned sel;
    int unsigned w;
    int unsigned h;
    int unsigned weff;
    int unsigned heff;
    int unsigned pixels;
    logic [CFG_DATA_W-1:0] thresh;
    bit geometry;

    board = new();
    rst_n = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.red   = '0;
    pix_if.green = '0;
    pix_if.blue  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_IMAGE_WIDTH;
    cfg_if.data  = '0;
    send_idle_pct = 37;
    recv_idle_pct = 71;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed frame, 3 x 6, unit threshold.
    write_cfg(CFG_IMAGE_WIDTH, 16'd3);
    write_cfg(CFG_IMAGE_HEIGHT, 16'd6);
    write_cfg(CFG_RATIO_THRESHOLD, 16'd256);
    // Dark pixel above a bright center: zero product, edge.
    send_pixel(8'hFF, 8'hFF, 8'hFF); send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF); send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    // Black center: never an edge.
    send_pixel(8'hC8, 8'hC8, 8'hC8); send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hC8, 8'hC8, 8'hC8);
    // One full channel at a time.
    send_pixel(8'hFF, 8'h00, 8'h00); send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF); send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    // Last row closes the frame.
    send_pixel(8'hFF, 8'hFF, 8'hFF); send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF);

    // Extremes: clamped geometry, zero and full threshold, tallest frame.
    run_phase(1'b1, 16'd0, 16'd1, 16'd0, 40, STYLE_MIXED, 1'b0);
    run_phase(1'b1, 16'd2, 16'd2, 16'hFFFF, 40, STYLE_FLAT, 1'b0);
    run_phase(1'b1, 16'd4, 16'hFFFF, 16'd256, 60, STYLE_MIXED, 1'b0);
    settle_block();
    write_cfg(CFG_UNUSED, CFG_DATA_W'($urandom));
    run_phase(1'b0, 16'd0, 16'd0, 16'd255, 30, STYLE_FLAT, 1'b0);

    geometry = 1'b1;
    while (random_pixels < RANDOM_PIXELS) begin
      sel = $urandom_range(0, 99);
      if (sel < 60)      w = $urandom_range(3, 12);
      else if (sel < 85) w = $urandom_range(13, 64);
      else if (sel < 93) w = $urandom_range(0, 2);
      else               w = $urandom_range(65, 200);
      sel = $urandom_range(0, 99);
      if (sel < 70)      h = $urandom_range(3, 8);
      else if (sel < 85) h = $urandom_range(0, 2);
      else if (sel < 95) h = $urandom_range(9, 20);
      else               h = 65535 - $urandom_range(0, 3);
      sel = $urandom_range(0, 99);
      if (sel < 45)      thresh = CFG_DATA_W'($urandom_range(192, 320));
      else if (sel < 55) thresh = '0;
      else if (sel < 65) thresh = '1;
      else if (sel < 75) thresh = CFG_DATA_W'($urandom_range(1, 16));
      else               thresh = CFG_DATA_W'($urandom);
      weff = (w < MIN_DIM) ? MIN_DIM : w;
      heff = (h < MIN_DIM) ? MIN_DIM : h;
      pixels = weff * heff * $urandom_range(1, 3) + $urandom_range(0, weff);
      if (pixels > 300) pixels = 300;
      if (pixels > RANDOM_PIXELS - random_pixels) pixels = RANDOM_PIXELS - random_pixels;
      // Now and then keep the frame going and change only the threshold.
      run_phase(geometry, {5'($urandom), 11'(w)}, 16'(h), thresh, pixels,
                pix_style_t'($urandom_range(0, 3)), 1'b1);
      geometry = ($urandom_range(0, 9) >= 3);
    end

    // Width above the line store clamps to it; a short run gives no results.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(1'b1, 16'hFFFF, 16'd3, 16'd256, WIDE_PIXELS, STYLE_FLAT, 1'b0);

    settle_block();
    if (board.flags_due.size() != 0)
      board.note_failure($sformatf("%0d flags never arrived", board.flags_due.size()));
    $display("Run: %0d pixels, %0d register writes, %0d settings, %0d cycles.",
             pix_taken, cfg_taken, settings_run, cycle_count);
    $display("Checked %0d flags, %0d of them edges, %0d frame ends; %0d mismatches.",
             board.flags_checked, board.flags_set, board.frames_done, board.failures);
    if (board.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> log_ratio_edge_detector.f
+incdir+rtl
rtl/lred_pkg.sv
rtl/lred_pix_if.sv
rtl/lred_res_if.sv
rtl/lred_cfg_if.sv
rtl/lred_ram.sv
rtl/log_ratio_edge_detector.sv
tb/tb_log_ratio_edge_detector.sv
